FILE: rtl/vector_similarity_top_k_defines.svh
// assertion macros for the checks of the top-level module
`ifndef VECTOR_SIMILARITY_TOP_K_DEFINES_SVH
`define VECTOR_SIMILARITY_TOP_K_DEFINES_SVH

// condition holds at every clock edge outside reset
`define VST_ASSERT(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define VST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/vst_pkg.sv
`default_nettype none
package vst_pkg;

    localparam int DIM_W     = 11;
    localparam int METRIC_W  = 2;
    localparam int LIMIT_W   = 5;
    localparam int ACT_W     = 2;
    localparam int VAL_W     = 16;
    localparam int ID_W      = 32;
    localparam int SCORE_W   = 48;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] CNT_MAX = '1;

    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CAND   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FINISH = 2'd2;

    localparam logic [METRIC_W-1:0] METRIC_COSINE = 2'd0;
    localparam logic [METRIC_W-1:0] METRIC_DOT    = 2'd1;
    localparam logic [METRIC_W-1:0] METRIC_DIST   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_MATCH   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LEN_ERR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_METRIC     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 2'd2;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [ID_W-1:0]           id;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/vst_ram.sv
`default_nettype none
module vst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                          wdata,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

FILE: rtl/vst_cell.sv
`default_nettype none
module vst_cell import vst_pkg::*; #(
    parameter int IDX = 0,
    parameter int KW  = 5
) (
    input  wire logic          aclk,
    input  wire cell_ctl_t     ctl,
    input  wire entry_t        cand,
    input  wire entry_t        prev_entry,
    input  wire entry_t        next_entry,
    input  wire logic          prev_better,
    input  wire logic [KW-1:0] kept,
    input  wire logic [KW-1:0] lim,
    output entry_t             entry,
    output logic               better,
    output logic               slot
);

    entry_t entry_reg;
    logic   valid;
    logic   in_lim;

    assign valid  = 32'(IDX) < 32'(kept);
    assign in_lim = 32'(IDX) < 32'(lim);
    // held entry ranks ahead: higher score, or equal score and smaller id
    assign better = valid && ((entry_reg.score > cand.score) ||
                    ((entry_reg.score == cand.score) && (entry_reg.id < cand.id)));
    assign slot   = in_lim && !better;
    assign entry  = entry_reg;

    always_ff @(posedge aclk) begin
        if (ctl.insert && slot) begin
            entry_reg <= prev_better ? cand : prev_entry;
        end else if (ctl.shift) begin
            entry_reg <= next_entry;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/vst_isqrt.sv
`default_nettype none
module vst_isqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] x,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0] rem_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;
    assign done  = done_reg;
    assign root  = res_reg[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (bit_reg == 64'd1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // each step tries the next root bit against the remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= x;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/vst_div.sv
`default_nettype none
module vst_div import vst_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic                      neg,
    input  wire logic [SCORE_W-1:0]        mag,
    input  wire logic [63:0]               den,
    output logic                           done,
    output logic signed [SCORE_W-1:0]      quot
);

    localparam logic [6:0]  LAST_STEP = 7'd93;
    localparam logic [40:0] Q_CAP     = 41'h100_0000_0000;

    logic [SCORE_W-1:0] dvd_reg;
    logic [63:0]        rem_reg;
    logic [40:0]        q_reg;
    logic [6:0]         step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [64:0]        r_sh;
    logic [64:0]        r_sub;
    logic               ge;
    logic [41:0]        q_sh;

    assign r_sh  = {rem_reg, dvd_reg[SCORE_W-1]};
    assign ge    = r_sh >= {1'b0, den};
    assign r_sub = r_sh - {1'b0, den};
    assign q_sh  = {q_reg, ge};
    assign done  = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= LAST_STEP;
            end else if (busy_reg) begin
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - 7'd1;
                end
            end
        end
    end

    // restoring division, one quotient bit per step, quotient clamped as it grows
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= mag;
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[SCORE_W-2:0], 1'b0};
            rem_reg <= ge ? r_sub[63:0] : r_sh[63:0];
            q_reg   <= (q_sh > {1'b0, Q_CAP}) ? Q_CAP : q_sh[40:0];
        end
    end

    always_comb begin
        if (neg) begin
            if (q_reg >= 41'h0_8000_0000) begin
                quot = -48'sh8000_0000;
            end else begin
                quot = -$signed({7'b0, q_reg});
            end
        end else begin
            if (q_reg > 41'h0_7FFF_FFFF) begin
                quot = 48'sh7FFF_FFFF;
            end else begin
                quot = $signed({7'b0, q_reg});
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/vector_similarity_top_k.sv
// top-k similarity search over streamed q1.15 vectors
// input stream: tuser carries the action (query element, candidate element, finish),
// tdata the element value and candidate id, tlast the final element of a vector
// a query element is written to the query store; a candidate element passes the query
// store read, the product stage and the accumulate stage before new input is accepted
// at a candidate's last element of the right length the score follows: dot directly,
// distance from one 64-bit integer root (two radicand bits per cycle), cosine from two
// roots, one 32x32 multiply and a 94-step divider (skipped with score zero when a norm
// is zero); then the candidate is inserted into the row of rank cells
// finish: one transaction per kept match in rank order, or one status transaction
// for an empty list or a length error; one result per cycle while the receiver
// takes them, the last waits in the output register while new input is accepted
// a stalled receiver holds the output register and the block waits with it
// reset (synchronous, active low) clears counters, sums, kept list and registers
// to dimensions 1, metric cosine, match limit 16; the query store is not cleared
// configuration: plain write port; the user must write it only while the block is idle, the block does not enforce this
`default_nettype none
`include "vector_similarity_top_k_defines.svh"
module vector_similarity_top_k import vst_pkg::*; #(
    parameter int MAX_DIMENSIONS = 1024,
    parameter int MAX_MATCHES    = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [47:0]          s_tdata,   // element_value [15:0], candidate_id [47:16]
    input  wire logic [1:0]           s_tuser,   // action [1:0]
    input  wire logic                 s_tlast,   // last_element
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [79:0]               m_tdata,   // match_id [31:0], match_score [79:32]
    output logic [1:0]                m_tuser,   // status [1:0]
    output logic                      m_tlast,   // last_result
    // configuration writes
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_wdata
);

    localparam int AW = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
    localparam int KW = $clog2(MAX_MATCHES + 1);

    // controller states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL    = 4'd1;
    localparam logic [3:0] ST_ACC    = 4'd2;
    localparam logic [3:0] ST_SCORE  = 4'd3;
    localparam logic [3:0] ST_SQRT   = 4'd4;
    localparam logic [3:0] ST_DEN    = 4'd5;
    localparam logic [3:0] ST_DIVGO  = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_INSERT = 4'd8;
    localparam logic [3:0] ST_EMIT   = 4'd9;

    // which root the shared root unit is working on
    localparam logic [1:0] PH_DIST  = 2'd0;
    localparam logic [1:0] PH_QNORM = 2'd1;
    localparam logic [1:0] PH_CNORM = 2'd2;

    localparam logic signed [SCORE_W-1:0] DOT_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] DOT_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    function automatic logic [SCORE_W-1:0] usat(input logic [SCORE_W-1:0] a,
                                                input logic [31:0] b);
        logic [SCORE_W:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[SCORE_W] ? {SCORE_W{1'b1}} : s[SCORE_W-1:0];
    endfunction

    // configuration registers
    logic [DIM_W-1:0]    cfg_dim_reg;
    logic [METRIC_W-1:0] cfg_metric_reg;
    logic [LIMIT_W-1:0]  cfg_limit_reg;

    // control and sums
    logic [3:0]                state_reg;
    logic [DIM_W-1:0]          cnt_reg;
    logic signed [SCORE_W-1:0] dot_reg;
    logic [SCORE_W-1:0]        qn_reg;
    logic [SCORE_W-1:0]        cn_reg;
    logic [SCORE_W-1:0]        dist_reg;
    logic [KW-1:0]             kept_reg;
    logic                      lerr_reg;
    logic [KW-1:0]             emit_left_reg;
    logic [STATUS_W-1:0]       emit_status_reg;
    logic [1:0]                phase_reg;

    // latched candidate element
    logic signed [VAL_W-1:0]   val_reg;
    logic [ID_W-1:0]           id_reg;
    logic                      last_reg;
    logic                      in_dim_reg;
    logic                      lenok_reg;

    // product stage
    logic signed [31:0]        pqv_reg;
    logic [31:0]               pqq_reg;
    logic [31:0]               pvv_reg;
    logic [31:0]               pdd_reg;

    // scoring
    logic [31:0]               rq_reg;
    logic [31:0]               rc_reg;
    logic [63:0]               den_reg;
    logic signed [SCORE_W-1:0] score_reg;

    // output register
    logic                      m_valid_reg;
    logic [ID_W-1:0]           m_id_reg;
    logic signed [SCORE_W-1:0] m_score_reg;
    logic [STATUS_W-1:0]       m_status_reg;
    logic                      m_last_reg;

    // input transaction fields
    logic                      accept;
    logic [ACT_W-1:0]          in_act;
    logic signed [VAL_W-1:0]   in_val;
    logic [ID_W-1:0]           in_id;
    logic                      in_last;

    logic                      in_dim;
    logic                      len_ok;
    logic [KW-1:0]             lim;
    logic [KW-1:0]             n_kept;
    logic                      is_cosine;
    logic                      out_free;
    logic                      placed;

    logic signed [VAL_W-1:0]   q_data;
    logic                      ram_we;
    logic [AW-1:0]             ram_addr;

    logic signed [31:0]        q_x;
    logic signed [31:0]        v_x;
    logic signed [33:0]        d_x;
    logic signed [31:0]        p_qv;
    logic signed [31:0]        p_qq;
    logic signed [31:0]        p_vv;
    logic signed [33:0]        p_dd;
    logic signed [SCORE_W:0]   dot_wide;
    logic signed [SCORE_W-1:0] dot_sat;

    logic                      sq_start;
    logic [63:0]               sq_x;
    logic                      sq_done;
    logic [31:0]               sq_root;

    logic                      div_start;
    logic                      div_done;
    logic signed [SCORE_W-1:0] div_quot;
    logic [SCORE_W-1:0]        dot_mag;

    cell_ctl_t                 cell_ctl;
    entry_t                    cand;
    entry_t                    cell_entry [MAX_MATCHES];
    logic [MAX_MATCHES-1:0]    better_vec;
    logic [MAX_MATCHES-1:0]    slot_vec;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = state_reg == ST_IDLE;
    assign in_act   = s_tuser;
    assign in_val   = $signed(s_tdata[15:0]);
    assign in_id    = s_tdata[47:16];
    assign in_last  = s_tlast;

    // element position checks against the configured length
    assign in_dim = (cnt_reg < cfg_dim_reg) && (32'(cnt_reg) < 32'(MAX_DIMENSIONS));
    assign len_ok = ((12'(cnt_reg) + 12'd1) == 12'(cfg_dim_reg)) &&
                    (32'(cfg_dim_reg) <= 32'(MAX_DIMENSIONS));

    // a limit above the row length acts as the row length
    always_comb begin
        if (32'(cfg_limit_reg) > 32'(MAX_MATCHES)) begin
            lim = KW'(MAX_MATCHES);
        end else begin
            lim = KW'(cfg_limit_reg);
        end
    end

    assign n_kept    = (kept_reg < lim) ? kept_reg : lim;
    assign is_cosine = (cfg_metric_reg != METRIC_DOT) && (cfg_metric_reg != METRIC_DIST);
    assign out_free  = !m_valid_reg || m_tready;
    assign placed    = |slot_vec;

    // query store: written by query elements, read for candidate elements
    assign ram_we   = accept && (in_act == ACT_QUERY) && in_dim;
    assign ram_addr = AW'(cnt_reg);

    vst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_DIMENSIONS)
    ) u_query_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_val),
        .rdata (q_data)
    );

    // products, exact in 2^-30 units
    assign q_x  = 32'(q_data);
    assign v_x  = 32'(val_reg);
    assign d_x  = 34'(q_data) - 34'(val_reg);
    assign p_qv = q_x * v_x;
    assign p_qq = q_x * q_x;
    assign p_vv = v_x * v_x;
    assign p_dd = d_x * d_x;

    // saturating dot accumulation
    assign dot_wide = {dot_reg[SCORE_W-1], dot_reg} + {{17{pqv_reg[31]}}, pqv_reg};
    always_comb begin
        if (dot_wide[SCORE_W] != dot_wide[SCORE_W-1]) begin
            dot_sat = dot_wide[SCORE_W] ? DOT_MIN : DOT_MAX;
        end else begin
            dot_sat = dot_wide[SCORE_W-1:0];
        end
    end

    // shared root unit launches
    always_comb begin
        sq_start = 1'b0;
        sq_x     = '0;
        if (state_reg == ST_SCORE) begin
            if (cfg_metric_reg == METRIC_DIST) begin
                sq_start = 1'b1;
                sq_x     = {16'b0, dist_reg};
            end else if (is_cosine) begin
                sq_start = 1'b1;
                sq_x     = {qn_reg, 16'b0};
            end
        end else if ((state_reg == ST_SQRT) && sq_done && (phase_reg == PH_QNORM)) begin
            sq_start = 1'b1;
            sq_x     = {cn_reg, 16'b0};
        end
    end

    vst_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .x       (sq_x),
        .done    (sq_done),
        .root    (sq_root)
    );

    assign div_start = state_reg == ST_DIVGO;
    assign dot_mag   = dot_reg[SCORE_W-1] ? SCORE_W'(-dot_reg) : dot_reg;

    vst_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .neg     (dot_reg[SCORE_W-1]),
        .mag     (dot_mag),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // rank row: insert a scored candidate, or shift towards the head while emitting
    assign cell_ctl.insert = state_reg == ST_INSERT;
    assign cell_ctl.shift  = (state_reg == ST_EMIT) && out_free &&
                             (emit_status_reg == STATUS_MATCH);
    assign cand.score      = score_reg;
    assign cand.id         = id_reg;

    for (genvar g = 0; g < MAX_MATCHES; g++) begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   prev_b;
        if (g == 0) begin : g_head
            assign prev_e = cand;
            assign prev_b = 1'b1;
        end else begin : g_body
            assign prev_e = cell_entry[g-1];
            assign prev_b = better_vec[g-1];
        end
        if (g == MAX_MATCHES - 1) begin : g_tail
            assign next_e = cell_entry[g];
        end else begin : g_mid
            assign next_e = cell_entry[g+1];
        end
        vst_cell #(
            .IDX (g),
            .KW  (KW)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (cell_ctl),
            .cand        (cand),
            .prev_entry  (prev_e),
            .next_entry  (next_e),
            .prev_better (prev_b),
            .kept        (n_kept),
            .lim         (lim),
            .entry       (cell_entry[g]),
            .better      (better_vec[g]),
            .slot        (slot_vec[g])
        );
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_dim_reg    <= DIM_W'(1);
            cfg_metric_reg <= METRIC_COSINE;
            cfg_limit_reg  <= LIMIT_W'(16);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DIMENSIONS: cfg_dim_reg    <= cfg_wdata;
                REG_METRIC:     cfg_metric_reg <= cfg_wdata[METRIC_W-1:0];
                REG_LIMIT:      cfg_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // controller, counter, sums and kept list length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            dot_reg         <= '0;
            qn_reg          <= '0;
            cn_reg          <= '0;
            dist_reg        <= '0;
            kept_reg        <= '0;
            lerr_reg        <= 1'b0;
            emit_left_reg   <= '0;
            emit_status_reg <= STATUS_MATCH;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if ((in_act == ACT_QUERY) || (in_act == ACT_CAND)) begin
                            if (in_last) begin
                                cnt_reg <= '0;
                            end else if (cnt_reg != CNT_MAX) begin
                                cnt_reg <= cnt_reg + DIM_W'(1);
                            end
                        end
                        if (in_act == ACT_QUERY) begin
                            if (in_last) begin
                                if (!len_ok) begin
                                    lerr_reg <= 1'b1;
                                end
                                dot_reg  <= '0;
                                qn_reg   <= '0;
                                cn_reg   <= '0;
                                dist_reg <= '0;
                            end
                        end else if (in_act == ACT_CAND) begin
                            state_reg <= ST_MUL;
                        end else if (in_act == ACT_FINISH) begin
                            emit_left_reg <= n_kept;
                            if (lerr_reg || (cnt_reg != '0)) begin
                                emit_status_reg <= STATUS_LEN_ERR;
                            end else if (n_kept == '0) begin
                                emit_status_reg <= STATUS_EMPTY;
                            end else begin
                                emit_status_reg <= STATUS_MATCH;
                            end
                            kept_reg  <= '0;
                            lerr_reg  <= 1'b0;
                            cnt_reg   <= '0;
                            dot_reg   <= '0;
                            qn_reg    <= '0;
                            cn_reg    <= '0;
                            dist_reg  <= '0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (in_dim_reg) begin
                        dot_reg  <= dot_sat;
                        qn_reg   <= usat(qn_reg, pqq_reg);
                        cn_reg   <= usat(cn_reg, pvv_reg);
                        dist_reg <= usat(dist_reg, pdd_reg);
                    end
                    if (last_reg && !lenok_reg) begin
                        lerr_reg  <= 1'b1;
                        dot_reg   <= '0;
                        qn_reg    <= '0;
                        cn_reg    <= '0;
                        dist_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end else if (last_reg) begin
                        state_reg <= ST_SCORE;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SCORE: begin
                    if (cfg_metric_reg == METRIC_DOT) begin
                        state_reg <= ST_INSERT;
                    end else begin
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sq_done) begin
                        unique case (phase_reg)
                            PH_DIST:  state_reg <= ST_INSERT;
                            PH_QNORM: state_reg <= ST_SQRT;
                            PH_CNORM: state_reg <= ST_DEN;
                            default:  state_reg <= ST_INSERT;
                        endcase
                    end
                end
                ST_DEN: begin
                    if ((rq_reg == '0) || (rc_reg == '0)) begin
                        state_reg <= ST_INSERT;
                    end else begin
                        state_reg <= ST_DIVGO;
                    end
                end
                ST_DIVGO: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_INSERT;
                    end
                end
                ST_INSERT: begin
                    if (placed) begin
                        kept_reg <= (n_kept < lim) ? n_kept + KW'(1) : lim;
                    end else begin
                        kept_reg <= n_kept;
                    end
                    dot_reg   <= '0;
                    qn_reg    <= '0;
                    cn_reg    <= '0;
                    dist_reg  <= '0;
                    state_reg <= ST_IDLE;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        if (emit_status_reg != STATUS_MATCH) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            emit_left_reg <= emit_left_reg - KW'(1);
                            if (emit_left_reg == KW'(1)) begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept && (in_act == ACT_CAND)) begin
            val_reg    <= in_val;
            id_reg     <= in_id;
            last_reg   <= in_last;
            in_dim_reg <= in_dim;
            lenok_reg  <= len_ok;
        end
        if (state_reg == ST_MUL) begin
            pqv_reg <= p_qv;
            pqq_reg <= p_qq;
            pvv_reg <= p_vv;
            pdd_reg <= p_dd[31:0];
        end
        if (state_reg == ST_SCORE) begin
            score_reg <= dot_reg;
            phase_reg <= (cfg_metric_reg == METRIC_DIST) ? PH_DIST : PH_QNORM;
        end
        if ((state_reg == ST_SQRT) && sq_done) begin
            unique case (phase_reg)
                PH_DIST:  score_reg <= -$signed({16'b0, sq_root});
                PH_QNORM: begin
                    rq_reg    <= sq_root;
                    phase_reg <= PH_CNORM;
                end
                PH_CNORM: rc_reg <= sq_root;
                default:  score_reg <= '0;
            endcase
        end
        if (state_reg == ST_DEN) begin
            score_reg <= '0;
            den_reg   <= rq_reg * rc_reg;
        end
        if ((state_reg == ST_DIV) && div_done) begin
            score_reg <= div_quot;
        end
    end

    // output register: loaded from the row head or with a status transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_EMIT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_EMIT) && out_free) begin
            if (emit_status_reg != STATUS_MATCH) begin
                m_id_reg     <= '0;
                m_score_reg  <= '0;
                m_status_reg <= emit_status_reg;
                m_last_reg   <= 1'b1;
            end else begin
                m_id_reg     <= cell_entry[0].id;
                m_score_reg  <= cell_entry[0].score;
                m_status_reg <= STATUS_MATCH;
                m_last_reg   <= emit_left_reg == KW'(1);
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_score_reg, m_id_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    // checks
    `VST_ASSERT(a_kept_bound, kept_reg <= KW'(MAX_MATCHES), "kept count beyond row length")
    `VST_ASSERT(a_root_owner, !sq_done || (state_reg == ST_SQRT), "root done outside root wait")
    `VST_ASSERT(a_div_owner, !div_done || (state_reg == ST_DIV), "divide done outside divide wait")
    `VST_ASSERT_NEXT(a_finish_clears, accept && (in_act == ACT_FINISH), (kept_reg == '0) && !lerr_reg && (state_reg == ST_EMIT), "finish did not clear the search")

endmodule
`default_nettype wire
